// File: src/mr3k_pkg.sv
// Shared types and decode constants for the MIPS R3000 instruction class decoder.
package mr3k_pkg;

    // Instruction class number, 0..66.
    typedef logic [6:0] t_class;
    typedef logic [5:0] t_opcode;
    typedef logic [4:0] t_regfield;
    typedef logic [5:0] t_funct;

    // Field positions inside the instruction word.
    localparam int OP_LSB = 26;
    localparam int RS_LSB = 21;
    localparam int RT_LSB = 16;

    // Primary opcodes that are decoded by a second field.
    localparam t_opcode OP_SPECIAL = 6'h00;
    localparam t_opcode OP_REGIMM  = 6'h01;
    localparam t_opcode OP_COP0    = 6'h10;

    // REGIMM rt codes.
    localparam t_regfield RT_BLTZ   = 5'h00;
    localparam t_regfield RT_BGEZ   = 5'h01;
    localparam t_regfield RT_BLTZAL = 5'h10;
    localparam t_regfield RT_BGEZAL = 5'h11;

    // COP0 rs codes.
    localparam t_regfield RS_MF = 5'h00;
    localparam t_regfield RS_CF = 5'h02;
    localparam t_regfield RS_MT = 5'h04;
    localparam t_regfield RS_CT = 5'h06;
    localparam t_regfield RS_CO = 5'h10;

    // COP0 function code for RFE.
    localparam t_funct FN_RFE = 6'h10;

    // Class numbers for the second-field decode, ROM fill and the range check.
    localparam t_class CLS_BLTZ     = 7'd50;
    localparam t_class CLS_BGEZ     = 7'd51;
    localparam t_class CLS_BLTZAL   = 7'd54;
    localparam t_class CLS_BGEZAL   = 7'd55;
    localparam t_class CLS_RESERVED = 7'd56;
    localparam t_class CLS_COP_UNUS = 7'd57;
    localparam t_class CLS_RFE      = 7'd60;
    localparam t_class CLS_MFC0     = 7'd61;
    localparam t_class CLS_MTC0     = 7'd62;
    localparam t_class CLS_CFC0     = 7'd63;
    localparam t_class CLS_CTC0     = 7'd64;
    localparam t_class CLS_LAST     = 7'd66;

endpackage

// File: src/mips_r3000_instruction_decoder_top.sv
// Top level of the MIPS R3000 instruction class decoder: table ROMs and class select.
//
//   Channel   Direction  Handshake           Payload
//   -------   ---------  ------------------  ----------------------------------------------
//   input     in         i_valid / o_ready   i_instr_word
//   result    out        o_valid / i_ready   o_instr_class, o_is_reserved, o_is_cop_unusable
//
// An accepted request passes through the registered read of the opcode and function
// ROMs, then the class select into the output register. One request is accepted per
// cycle while the input is not stalled. Reset clears the stage valid bits only. A
// stalled result holds while the ROM stage still takes one more request; the input
// stalls only when both stages are full.
module mips_r3000_instruction_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_instr_class,
    output logic        o_is_reserved,
    output logic        o_is_cop_unusable
);

    localparam mr3k_pkg::t_class CR = mr3k_pkg::CLS_RESERVED;
    localparam mr3k_pkg::t_class CU = mr3k_pkg::CLS_COP_UNUS;

    // Primary opcode ROM; SPECIAL, REGIMM and COP0 slots are resolved after the read.
    localparam mr3k_pkg::t_class PRIM_ROM [64] = '{
        CR,    CR,    7'd44, 7'd45, 7'd48, 7'd49, 7'd53, 7'd52,
        7'd16, 7'd17, 7'd20, 7'd21, 7'd26, 7'd27, 7'd28, 7'd35,
        CR,    CU,    CU,    CU,    CR,    CR,    CR,    CR,
        CR,    CR,    CR,    CR,    CR,    CR,    CR,    CR,
        7'd0,  7'd2,  7'd9,  7'd4,  7'd1,  7'd3,  7'd8,  CR,
        7'd5,  7'd6,  7'd11, 7'd7,  CR,    CR,    7'd10, CR,
        7'd65, CU,    CU,    CU,    CR,    CR,    CR,    CR,
        7'd66, CU,    CU,    CU,    CR,    CR,    CR,    CR
    };

    // SPECIAL function ROM.
    localparam mr3k_pkg::t_class SPEC_ROM [64] = '{
        7'd32, CR,    7'd33, 7'd34, 7'd29, CR,    7'd30, 7'd31,
        7'd46, 7'd47, CR,    CR,    7'd58, 7'd59, CR,    CR,
        7'd40, 7'd42, 7'd41, 7'd43, CR,    CR,    CR,    CR,
        7'd36, 7'd37, 7'd38, 7'd39, CR,    CR,    CR,    CR,
        7'd12, 7'd13, 7'd14, 7'd15, 7'd22, 7'd23, 7'd24, 7'd25,
        CR,    CR,    7'd18, 7'd19, CR,    CR,    CR,    CR,
        CR,    CR,    CR,    CR,    CR,    CR,    CR,    CR,
        CR,    CR,    CR,    CR,    CR,    CR,    CR,    CR
    };

    mr3k_pkg::t_opcode   w_op;
    mr3k_pkg::t_funct    w_fn;

    logic                r_a_valid;
    mr3k_pkg::t_class    r_prim;
    mr3k_pkg::t_class    r_spec;
    mr3k_pkg::t_opcode   r_op;
    mr3k_pkg::t_regfield r_rs;
    mr3k_pkg::t_regfield r_rt;
    logic                r_fn_rfe;

    logic                r_o_valid;
    mr3k_pkg::t_class    r_class;
    mr3k_pkg::t_class    n_class;

    logic                w_o_en;
    logic                w_a_en;

    // Stage enables: each stage loads when it is empty or its contents move on.
    assign w_o_en = !r_o_valid || i_ready;
    assign w_a_en = !r_a_valid || w_o_en;
    assign o_ready = w_a_en;

    assign w_op = i_instr_word[mr3k_pkg::OP_LSB +: 6];
    assign w_fn = i_instr_word[5:0];

    // ROM stage: registered table reads and the fields the select stage needs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_en) begin
            r_a_valid <= i_valid;
        end
        if (w_a_en && i_valid) begin
            r_prim   <= PRIM_ROM[w_op];
            r_spec   <= SPEC_ROM[w_fn];
            r_op     <= w_op;
            r_rs     <= i_instr_word[mr3k_pkg::RS_LSB +: 5];
            r_rt     <= i_instr_word[mr3k_pkg::RT_LSB +: 5];
            r_fn_rfe <= (w_fn == mr3k_pkg::FN_RFE);
        end
    end

    // Class select for the opcodes that decode through a second field; other opcodes take the primary ROM class.
    always_comb begin
        case (r_op)
            mr3k_pkg::OP_SPECIAL: begin
                n_class = r_spec;
            end
            mr3k_pkg::OP_REGIMM: begin
                case (r_rt)
                    mr3k_pkg::RT_BLTZ:   n_class = mr3k_pkg::CLS_BLTZ;
                    mr3k_pkg::RT_BGEZ:   n_class = mr3k_pkg::CLS_BGEZ;
                    mr3k_pkg::RT_BLTZAL: n_class = mr3k_pkg::CLS_BLTZAL;
                    mr3k_pkg::RT_BGEZAL: n_class = mr3k_pkg::CLS_BGEZAL;
                    default:             n_class = mr3k_pkg::CLS_RESERVED;
                endcase
            end
            mr3k_pkg::OP_COP0: begin
                case (r_rs)
                    mr3k_pkg::RS_MF: n_class = mr3k_pkg::CLS_MFC0;
                    mr3k_pkg::RS_CF: n_class = mr3k_pkg::CLS_CFC0;
                    mr3k_pkg::RS_MT: n_class = mr3k_pkg::CLS_MTC0;
                    mr3k_pkg::RS_CT: n_class = mr3k_pkg::CLS_CTC0;
                    mr3k_pkg::RS_CO: begin
                        n_class = r_fn_rfe ? mr3k_pkg::CLS_RFE : mr3k_pkg::CLS_RESERVED;
                    end
                    default:         n_class = mr3k_pkg::CLS_RESERVED;
                endcase
            end
            default: begin
                n_class = r_prim;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_en) begin
            r_o_valid <= r_a_valid;
        end
        if (w_o_en && r_a_valid) begin
            r_class <= n_class;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_instr_class     = r_class;
    assign o_is_reserved     = (r_class == mr3k_pkg::CLS_RESERVED);
    assign o_is_cop_unusable = (r_class == mr3k_pkg::CLS_COP_UNUS);

endmodule

// File: src/mr3k_checker.sv
// Port-level checks for the instruction class decoder and their binding to the top level.
module mr3k_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [6:0]  o_instr_class,
    input logic        o_is_reserved,
    input logic        o_is_cop_unusable
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The reserved flag agrees with the class number.
    a_rsv_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_reserved == (o_instr_class == mr3k_pkg::CLS_RESERVED)))
        else $error("reserved flag disagrees with class");

    // The coprocessor-unusable flag agrees with the class number.
    a_cpu_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_cop_unusable == (o_instr_class == mr3k_pkg::CLS_COP_UNUS)))
        else $error("coprocessor-unusable flag disagrees with class");

    // Class numbers stay inside the defined range.
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_instr_class <= mr3k_pkg::CLS_LAST))
        else $error("class number out of range");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_instr_class)))
        else $error("stalled result changed");

endmodule

bind mips_r3000_instruction_decoder_top mr3k_checker u_mr3k_checker (.*);
